/* hw/rtl/utf8ls_pkg.sv */
package utf8ls_pkg;

  // most bytes that one input beat can release
  localparam int unsigned MAX_RESULTS = 4;

  localparam logic [7:0] SPACE_BYTE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;

  // prefix masks and patterns
  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_BITS  = 8'h80;
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_BITS = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_BITS = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_BITS = 8'hF0;

  localparam logic [2:0] SEQ_NONE = 3'd0;
  localparam logic [2:0] SEQ_TWO  = 3'd2;
  localparam logic [2:0] SEQ_THREE = 3'd3;
  localparam logic [2:0] SEQ_FOUR = 3'd4;

  // bytes released by one step, in order, with the end-of-string mark
  typedef struct packed {
    logic [2:0]      count;
    logic [3:0][7:0] bytes;
    logic            last;
  } group_t;

endpackage

/* hw/rtl/utf8ls_in_if.sv */
interface utf8ls_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

/* hw/rtl/utf8ls_out_if.sv */
interface utf8ls_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink (input valid, input out_byte, input out_last, output ready);
endinterface

/* hw/rtl/utf8_lossy_sanitizer.sv */
// channel | dir | beat payload          | notes
// --------+-----+-----------------------+------------------------------------
// raw     | in  | data_byte, last_byte  | one text byte, last_byte ends string
// clean   | out | out_byte, out_last    | sanitized byte, out_last on final one
//
// one raw beat per cycle while the queue has room; a beat waits in the input
// register, then its 0..4 result bytes enter the output queue together
// the output queue drains one byte per cycle while clean is ready; raw.ready
// drops only while the queue lacks room for a worst-case group of four bytes
// rst is synchronous and active high: closes any open sequence, empties queue
// a stall on clean backs up into the queue and then the input register
module utf8_lossy_sanitizer #(
  parameter int unsigned QUEUE_DEPTH = 8   // power of two, at least 8
) (
  input  logic         clk,
  input  logic         rst,
  utf8ls_in_if.sink    raw,
  utf8ls_out_if.source clean
);

  // input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;

  logic               room;
  logic               advance;
  utf8ls_pkg::group_t group;

  // the held beat moves on once the queue can take its whole group
  assign advance   = in_valid && room;
  assign raw.ready = !in_valid || room;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (raw.valid && raw.ready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (raw.valid && raw.ready) begin
      in_byte <= raw.data_byte;
      in_last <= raw.last_byte;
    end
  end

  // sequence tracking and byte rewriting
  utf8ls_step u_step (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .data_byte (in_byte),
    .last_byte (in_last),
    .group     (group)
  );

  // result queue: takes a whole group, gives one byte a beat
  utf8ls_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (advance),
    .group (group),
    .room  (room),
    .clean (clean)
  );

endmodule

/* hw/rtl/utf8ls_step.sv */
module utf8ls_step (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  logic [7:0]          data_byte,
  input  logic                last_byte,
  output utf8ls_pkg::group_t  group
);

  logic [7:0] held [3];
  logic [7:0] held_next [3];
  logic [1:0] held_count;
  logic [1:0] held_count_next;
  logic [2:0] sequence_length;
  logic [2:0] sequence_length_next;

  logic is_cont;
  logic keep_ascii;
  logic [2:0] lead_len;

  assign is_cont = (data_byte & utf8ls_pkg::CONT_MASK) == utf8ls_pkg::CONT_BITS;
  assign keep_ascii = (data_byte == utf8ls_pkg::CHAR_TAB) || (data_byte == utf8ls_pkg::CHAR_LF) ||
                      (data_byte == utf8ls_pkg::CHAR_CR) || (data_byte >= utf8ls_pkg::SPACE_BYTE);

  always_comb begin
    if ((data_byte & utf8ls_pkg::LEAD2_MASK) == utf8ls_pkg::LEAD2_BITS) begin
      lead_len = utf8ls_pkg::SEQ_TWO;
    end else if ((data_byte & utf8ls_pkg::LEAD3_MASK) == utf8ls_pkg::LEAD3_BITS) begin
      lead_len = utf8ls_pkg::SEQ_THREE;
    end else if ((data_byte & utf8ls_pkg::LEAD4_MASK) == utf8ls_pkg::LEAD4_BITS) begin
      lead_len = utf8ls_pkg::SEQ_FOUR;
    end else begin
      lead_len = utf8ls_pkg::SEQ_NONE;
    end
  end

  // unused slots default to space, so a flush only advances the count
  always_comb begin
    held_next            = held;
    held_count_next      = held_count;
    sequence_length_next = sequence_length;
    group.count          = 3'd0;
    group.bytes          = {4{utf8ls_pkg::SPACE_BYTE}};
    group.last           = last_byte;

    if ((sequence_length != utf8ls_pkg::SEQ_NONE) && is_cont) begin
      if (({1'b0, held_count} + 3'd1) >= sequence_length) begin
        // sequence complete
        for (int i = 0; i < 3; i++) begin
          if (2'(i) < held_count) begin
            group.bytes[group.count[1:0]] = held[i];
            group.count = group.count + 3'd1;
          end
        end
        group.bytes[group.count[1:0]] = data_byte;
        group.count = group.count + 3'd1;
        held_count_next      = 2'd0;
        sequence_length_next = utf8ls_pkg::SEQ_NONE;
      end else if (held_count < 2'd3) begin
        held_next[held_count] = data_byte;
        held_count_next       = held_count + 2'd1;
      end else begin
        group.count          = {1'b0, held_count} + 3'd1;
        held_count_next      = 2'd0;
        sequence_length_next = utf8ls_pkg::SEQ_NONE;
      end
    end else begin
      // broken sequence: held bytes leave as spaces
      if (sequence_length != utf8ls_pkg::SEQ_NONE) begin
        group.count          = {1'b0, held_count};
        held_count_next      = 2'd0;
        sequence_length_next = utf8ls_pkg::SEQ_NONE;
      end
      if (!data_byte[7]) begin
        group.bytes[group.count[1:0]] = keep_ascii ? data_byte : utf8ls_pkg::SPACE_BYTE;
        group.count = group.count + 3'd1;
      end else if (lead_len == utf8ls_pkg::SEQ_NONE) begin
        group.count = group.count + 3'd1;
      end else begin
        held_next[0]         = data_byte;
        held_count_next      = 2'd1;
        sequence_length_next = lead_len;
      end
    end

    // truncated at end of string
    if (last_byte) begin
      group.count          = group.count + {1'b0, held_count_next};
      held_count_next      = 2'd0;
      sequence_length_next = utf8ls_pkg::SEQ_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count      <= 2'd0;
      sequence_length <= utf8ls_pkg::SEQ_NONE;
    end else if (advance) begin
      held_count      <= held_count_next;
      sequence_length <= sequence_length_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      held <= held_next;
    end
  end

`ifndef SYNTHESIS
  a_open_seq_consistent: assert property (@(posedge clk) disable iff (rst)
    (sequence_length != utf8ls_pkg::SEQ_NONE) |->
      ((held_count != 2'd0) && ({1'b0, held_count} < sequence_length)))
    else $error("open sequence with bad held count");

  a_last_closes: assert property (@(posedge clk) disable iff (rst)
    (advance && last_byte) |=>
      ((sequence_length == utf8ls_pkg::SEQ_NONE) && (held_count == 2'd0)))
    else $error("sequence still open after end of string");

  a_last_emits: assert property (@(posedge clk) disable iff (rst)
    (advance && last_byte) |-> (group.count != 3'd0))
    else $error("end of string released no byte");
`endif

endmodule

/* hw/rtl/utf8ls_queue.sv */
module utf8ls_queue #(
  parameter int unsigned DEPTH = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  utf8ls_pkg::group_t group,
  output logic               room,
  utf8ls_out_if.source       clean
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic [8:0]    mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;
  logic          pop;
  logic [AW:0]   push_n;

  assign pop    = (count != '0) && clean.ready;
  assign push_n = push ? (AW + 1)'(group.count) : '0;
  // worst-case group must fit without credit for this cycle's pop
  assign room   = count <= (AW + 1)'(DEPTH - utf8ls_pkg::MAX_RESULTS);

  assign clean.valid    = count != '0;
  assign clean.out_byte = mem[rd_ptr][8:1];
  assign clean.out_last = mem[rd_ptr][0];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push_n[AW-1:0];
      if (pop) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      count <= count + push_n - (AW + 1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < utf8ls_pkg::MAX_RESULTS; k++) begin
      if (push && (3'(k) < group.count)) begin
        mem[wr_ptr + AW'(k)] <= {group.bytes[k],
                                 group.last && (3'(k) == (group.count - 3'd1))};
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= (AW + 1)'(DEPTH))
    else $error("output queue overflow");

  a_push_needs_room: assert property (@(posedge clk) disable iff (rst)
    push |-> room)
    else $error("group pushed without room");

  a_push_fills: assert property (@(posedge clk) disable iff (rst)
    (push && (group.count != 3'd0)) |=> (count != '0))
    else $error("pushed bytes lost");
`endif

endmodule

/* test/utf8_lossy_sanitizer_tb.sv */
module utf8_lossy_sanitizer_tb;

  // one raw beat waiting to be offered
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } raw_beat_t;

  // one sanitized beat the block should deliver
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } clean_beat_t;

  // generous cap, far above the slowest legal run
  localparam int unsigned CYCLE_LIMIT = 400000;
  // receiver hold-off used to back the block up into its input
  localparam int unsigned HOLD_CYCLES = 300;
  // cycles allowed after the last expected beat for stray output
  localparam int unsigned TAIL_CYCLES = 32;

  logic clk;
  logic rst;

  utf8ls_in_if  raw ();
  utf8ls_out_if clean ();

  utf8_lossy_sanitizer u_dut (
    .clk   (clk),
    .rst   (rst),
    .raw   (raw),
    .clean (clean)
  );

  raw_beat_t   raw_pending[$];     // beats not yet offered to the block
  clean_beat_t expected_clean[$];  // sanitized beats still owed by the block
  logic [7:0]  step_bytes[$];      // bytes released by the beat being predicted

  // predictor state: the open multi-byte sequence
  logic [7:0]  open_bytes[3];
  int unsigned open_count;
  logic [2:0]  open_len;

  // idling controls, percent of cycles
  int unsigned send_idle_pct;
  int unsigned sink_stall_pct;

  // long receiver hold-off, requested by the stimulus and timed by its own process
  int unsigned hold_asked;
  int unsigned hold_granted;
  int unsigned hold_left;

  logic        raw_taken;          // raw beat accepted at the last rising edge
  int unsigned failures;
  int unsigned cycle_count;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // appends one released byte
  function automatic void put_byte(input logic [7:0] b);
    step_bytes.insert(step_bytes.size(), b);
  endfunction

  // held lead and continuations leave as spaces, sequence closes
  function automatic void flush_open();
    for (int i = 0; i < open_count; i++) put_byte(utf8ls_pkg::SPACE_BYTE);
    open_count = 0;
    open_len   = utf8ls_pkg::SEQ_NONE;
  endfunction

  // a byte seen with no sequence open
  function automatic void take_fresh(input logic [7:0] b);
    logic [2:0] len;
    len = utf8ls_pkg::SEQ_NONE;
    if (!b[7]) begin
      // ascii: controls other than tab, lf, cr turn into spaces; delete passes
      if (b == utf8ls_pkg::CHAR_TAB || b == utf8ls_pkg::CHAR_LF ||
          b == utf8ls_pkg::CHAR_CR || b >= utf8ls_pkg::SPACE_BYTE)
        put_byte(b);
      else
        put_byte(utf8ls_pkg::SPACE_BYTE);
      return;
    end
    if ((b & utf8ls_pkg::LEAD2_MASK) == utf8ls_pkg::LEAD2_BITS)
      len = utf8ls_pkg::SEQ_TWO;
    else if ((b & utf8ls_pkg::LEAD3_MASK) == utf8ls_pkg::LEAD3_BITS)
      len = utf8ls_pkg::SEQ_THREE;
    else if ((b & utf8ls_pkg::LEAD4_MASK) == utf8ls_pkg::LEAD4_BITS)
      len = utf8ls_pkg::SEQ_FOUR;
    if (len == utf8ls_pkg::SEQ_NONE) begin
      // stray continuation or an invalid lead byte
      put_byte(utf8ls_pkg::SPACE_BYTE);
      return;
    end
    open_bytes[0] = b;
    open_count    = 1;
    open_len      = len;
  endfunction

  // works out the sanitized beats caused by one accepted raw beat
  function automatic void sanitize_step(input logic [7:0] b, input logic ends);
    clean_beat_t beat;
    step_bytes.delete();
    if (open_len != utf8ls_pkg::SEQ_NONE) begin
      if ((b & utf8ls_pkg::CONT_MASK) == utf8ls_pkg::CONT_BITS) begin
        if (open_count + 1 >= open_len) begin
          // sequence complete: everything passes unchanged
          for (int i = 0; i < open_count; i++) put_byte(open_bytes[i]);
          put_byte(b);
          open_count = 0;
          open_len   = utf8ls_pkg::SEQ_NONE;
        end else begin
          open_bytes[open_count] = b;
          open_count++;
        end
      end else begin
        // broken sequence: held bytes become spaces, breaker starts over
        flush_open();
        take_fresh(b);
      end
    end else begin
      take_fresh(b);
    end
    // string ends: anything still open is truncated into spaces
    if (ends) flush_open();
    foreach (step_bytes[i]) begin
      beat.data = step_bytes[i];
      beat.last = ends && (i == step_bytes.size() - 1);
      expected_clean.insert(expected_clean.size(), beat);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // clock, timeout, hold-off timer
  // ---------------------------------------------------------------------------

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // counts out one long receiver stall each time the stimulus asks for one
  always @(posedge clk) begin
    if (rst) begin
      hold_left    <= 0;
      hold_granted <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_granted != hold_asked) begin
      hold_left    <= HOLD_CYCLES;
      hold_granted <= hold_asked;
    end
  end

  // ---------------------------------------------------------------------------
  // driver: raw side offers beats, clean side throttles ready, both at falling edge
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    if (rst) begin
      raw.valid <= 1'b0;
    end else if (!raw.valid || raw_taken) begin
      // free to offer the next beat, or to idle
      if (raw_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        raw.valid     <= 1'b1;
        raw.data_byte <= raw_pending[0].data;
        raw.last_byte <= raw_pending[0].last;
        void'(raw_pending.pop_front());
      end else begin
        raw.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_left != 0)
      clean.ready <= 1'b0;
    else
      clean.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // monitor: predicts on raw beats, checks clean beats, at rising edge
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    clean_beat_t want;
    if (rst) begin
      raw_taken <= 1'b0;
    end else begin
      raw_taken <= raw.valid && raw.ready;
      // predict first so a same-edge delivery would still find its entry
      if (raw.valid && raw.ready) sanitize_step(raw.data_byte, raw.last_byte);
      if (clean.valid && clean.ready) begin
        if (expected_clean.size() == 0) begin
          $error("unexpected clean beat: out_byte %h out_last %b",
                 clean.out_byte, clean.out_last);
          failures++;
        end else begin
          want = expected_clean.pop_front();
          if (clean.out_byte !== want.data) begin
            $error("out_byte mismatch: expected %h actual %h", want.data, clean.out_byte);
            failures++;
          end
          if (clean.out_last !== want.last) begin
            $error("out_last mismatch: expected %b actual %b", want.last, clean.out_last);
            failures++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  task automatic push_raw(input logic [7:0] b, input logic ends);
    raw_beat_t beat;
    beat.data = b;
    beat.last = ends;
    raw_pending.insert(raw_pending.size(), beat);
  endtask

  // one string of random tokens: mostly ascii and whole sequences,
  // the rest controls, cut sequences, stray continuations and invalid leads
  task automatic add_random_string(output int unsigned added);
    logic [7:0]  text[$];
    int unsigned tokens;
    int unsigned roll;
    int unsigned len;
    int unsigned keep;
    tokens = $urandom_range(12, 1);
    repeat (tokens) begin
      roll = $urandom_range(99);
      if (roll < 35) begin
        text.insert(text.size(), 8'($urandom_range(8'h7F, 8'h20)));
      end else if (roll < 43) begin
        text.insert(text.size(), 8'($urandom_range(8'h1F, 8'h00)));
      end else if (roll < 80) begin
        len  = $urandom_range(4, 2);
        // at 70 and above the sequence is cut short and left open to whatever follows
        keep = (roll < 70) ? len : $urandom_range(len - 1, 1);
        case (len)
          2: begin
            text.insert(text.size(), utf8ls_pkg::LEAD2_BITS | 8'($urandom_range(8'h1F)));
          end
          3: begin
            text.insert(text.size(), utf8ls_pkg::LEAD3_BITS | 8'($urandom_range(8'h0F)));
          end
          default: begin
            text.insert(text.size(), utf8ls_pkg::LEAD4_BITS | 8'($urandom_range(8'h07)));
          end
        endcase
        for (int k = 1; k < keep; k++)
          text.insert(text.size(), utf8ls_pkg::CONT_BITS | 8'($urandom_range(8'h3F)));
      end else if (roll < 90) begin
        text.insert(text.size(), utf8ls_pkg::CONT_BITS | 8'($urandom_range(8'h3F)));
      end else begin
        text.insert(text.size(), 8'($urandom_range(8'hFF, 8'hF8)));
      end
    end
    foreach (text[i]) push_raw(text[i], i == text.size() - 1);
    added = text.size();
  endtask

  task automatic add_text(input int unsigned byte_target);
    int unsigned total;
    int unsigned got;
    total = 0;
    while (total < byte_target) begin
      add_random_string(got);
      total += got;
    end
  endtask

  // wait until every queued beat went in and every expected beat came out
  task automatic drain();
    while (raw_pending.size() != 0 || raw.valid || expected_clean.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    rst            = 1'b1;
    raw.valid      = 1'b0;
    raw.data_byte  = 8'h00;
    raw.last_byte  = 1'b0;
    clean.ready    = 1'b0;
    send_idle_pct  = 0;
    sink_stall_pct = 0;
    hold_asked     = 0;
    failures       = 0;
    cycle_count    = 0;
    open_count     = 0;
    open_len       = utf8ls_pkg::SEQ_NONE;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: ascii extremes and controls, delete, stray and invalid bytes
    push_raw(8'h00, 1'b0);
    push_raw(utf8ls_pkg::CHAR_TAB, 1'b0);
    push_raw(utf8ls_pkg::CHAR_LF, 1'b0);
    push_raw(utf8ls_pkg::CHAR_CR, 1'b0);
    push_raw(8'h1F, 1'b0);
    push_raw(utf8ls_pkg::SPACE_BYTE, 1'b0);
    push_raw(8'h7F, 1'b1);
    push_raw(8'h80, 1'b0);
    push_raw(8'hF8, 1'b0);
    push_raw(8'hFF, 1'b1);
    // whole two, three and four byte sequences
    push_raw(8'hC3, 1'b0);
    push_raw(8'hA9, 1'b0);
    push_raw(8'hE2, 1'b0);
    push_raw(8'h82, 1'b0);
    push_raw(8'hAC, 1'b0);
    push_raw(8'hF0, 1'b0);
    push_raw(8'h9F, 1'b0);
    push_raw(8'h98, 1'b0);
    push_raw(8'h80, 1'b1);
    // broken by ascii, broken by a new lead, then truncated at string end
    push_raw(8'hE2, 1'b0);
    push_raw(8'h41, 1'b0);
    push_raw(8'hF4, 1'b0);
    push_raw(8'hDF, 1'b0);
    push_raw(8'hBF, 1'b0);
    push_raw(8'hF0, 1'b1);
    add_text(90);
    drain();

    // sender idling only
    send_idle_pct = 45;
    add_text(90);
    drain();

    // receiver stalling only
    send_idle_pct  = 0;
    sink_stall_pct = 45;
    add_text(90);
    drain();

    // both sides idling
    send_idle_pct  = 38;
    sink_stall_pct = 38;
    add_text(90);
    drain();

    // long receiver hold-off while the sender keeps offering beats
    send_idle_pct  = 0;
    sink_stall_pct = 0;
    hold_asked     = hold_asked + 1;
    add_text(60);
    drain();

    // room for any stray beat after the last one expected
    repeat (TAIL_CYCLES) @(posedge clk);
    if (failures == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
